// ===== sv/ghal_pkg.sv =====
// Shared types, codes and default sizes for the generational handle allocator.
// No dependencies; imported by ghal_ram and generational_handle_allocator_core.
package ghal_pkg;

	// default table geometry
	localparam int SLOTS_DEF        = 256;
	localparam int VERSION_BITS_DEF = 32;

	// fixed beat field widths
	localparam int FUNC_W = 2;
	localparam int IDX_W  = 8;
	localparam int VER_W  = 32;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC   = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_CHECK   = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_LIVE = 2'd3;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_BUMP,
		ST_CLR
	} state_t;

endpackage

// ===== sv/generational_handle_allocator_core.sv =====
// Generational handle allocator: check, release and fresh-slot allocate register a result
// from the execute state; allocate from the free stack reads the stack, then the version,
// and registers from the bump state; clear walks the used slots one slot per cycle
// through the slot memory. The next beat is accepted the cycle after a result is
// registered, while it still waits. Reset clears the counters, sequencer and result valid;
// the memories are not cleared. Depends on ghal_pkg and ghal_ram.
module generational_handle_allocator_core
	import ghal_pkg::*;
#(
	parameter int SLOTS        = SLOTS_DEF,
	parameter int VERSION_BITS = VERSION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [IDX_W-1:0]  slot_index,
	input  logic [VER_W-1:0]  handle_version,
	input  logic [KIND_W-1:0] asset_kind,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [IDX_W-1:0]  out_index,
	output logic [VER_W-1:0]  out_version,
	output logic              handle_ok,
	output logic              kind_matches,
	output logic [STAT_W-1:0] status
);

	localparam int IW    = $clog2(SLOTS);
	localparam int CNTW  = $clog2(SLOTS + 1);
	localparam int CW    = (CNTW > IDX_W) ? CNTW : IDX_W;
	localparam int VB    = VERSION_BITS;
	localparam int META_W = KIND_W + 1;

	// control state
	state_t            state_q, state_d;
	logic [CNTW-1:0]   used_q, fc_q, clr_q, fc_dec;

	// captured request
	func_t             op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [VER_W-1:0]  hver_q;
	logic [KIND_W-1:0] kind_q;
	logic [IW-1:0]     s_q;

	// result register
	logic              rsp_valid_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [VER_W-1:0]  out_version_q;
	logic              handle_ok_q, kind_matches_q;
	logic [STAT_W-1:0] status_q;

	// memory ports
	logic              meta_we, ver_we, stk_we;
	logic [IW-1:0]     meta_waddr, ver_waddr, stk_waddr;
	logic [IW-1:0]     meta_raddr, ver_raddr, stk_raddr;
	logic [META_W-1:0] meta_wdata, meta_rdata;
	logic [VB-1:0]     ver_wdata, ver_rdata, ver_inc;
	logic [IW-1:0]     stk_wdata, stk_rdata;

	// sequencer controls
	logic              accept, fire, done;
	logic              used_inc, fc_inc, fc_dec_en, fc_load, clr_inc;
	logic [IW-1:0]     addr_in, addr_q;
	logic              idx_oor, live;
	logic [IDX_W-1:0]  res_index;
	logic [VER_W-1:0]  res_version;
	logic              res_ok, res_km;
	logic [STAT_W-1:0] res_status;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign fire      = !rsp_valid_q || !rsp_stall;
	assign fc_dec    = fc_q - CNTW'(1);
	assign addr_in   = IW'(slot_index);
	assign addr_q    = IW'(idx_q);
	assign idx_oor   = (CW'(idx_q) >= CW'(used_q));
	assign live      = meta_rdata[KIND_W];
	assign ver_inc   = ver_rdata + VB'(1);

	// slot memory: live bit and kind
	ghal_ram #(.DEPTH(SLOTS), .WIDTH(META_W)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	// version memory
	ghal_ram #(.DEPTH(SLOTS), .WIDTH(VB)) u_ver (
		.clk   (clk),
		.we    (ver_we),
		.waddr (ver_waddr),
		.wdata (ver_wdata),
		.raddr (ver_raddr),
		.rdata (ver_rdata)
	);

	// free stack memory
	ghal_ram #(.DEPTH(SLOTS), .WIDTH(IW)) u_stk (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// select read addresses; hold them while a state waits on the result register
	always_comb begin
		meta_raddr = (state_q == ST_IDLE) ? addr_in : addr_q;
		stk_raddr  = fc_dec[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				ver_raddr = addr_in;
			end
			ST_EXEC: begin
				ver_raddr = (op_q == FUNC_ALLOC) ? stk_rdata : addr_q;
			end
			ST_BUMP: begin
				ver_raddr = s_q;
			end
			default: begin
				ver_raddr = addr_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (op_q)
					FUNC_ALLOC: begin
						if (fc_q != '0) state_d = ST_BUMP;
						else if (fire) state_d = ST_IDLE;
					end
					FUNC_CLEAR: begin
						state_d = ST_CLR;
					end
					default: begin
						if (fire) state_d = ST_IDLE;
					end
				endcase
			end
			ST_BUMP: begin
				if (fire) state_d = ST_IDLE;
			end
			ST_CLR: begin
				if (clr_q == used_q && fire) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory writes, counter updates and result per state
	always_comb begin
		meta_we     = 1'b0;
		meta_waddr  = addr_q;
		meta_wdata  = '0;
		ver_we      = 1'b0;
		ver_waddr   = addr_q;
		ver_wdata   = '0;
		stk_we      = 1'b0;
		stk_waddr   = fc_q[IW-1:0];
		stk_wdata   = addr_q;
		done        = 1'b0;
		used_inc    = 1'b0;
		fc_inc      = 1'b0;
		fc_dec_en   = 1'b0;
		fc_load     = 1'b0;
		clr_inc     = 1'b0;
		res_index   = '0;
		res_version = '0;
		res_ok      = 1'b0;
		res_km      = 1'b0;
		res_status  = STAT_OK;
		case (state_q)
			ST_EXEC: begin
				case (op_q)
					FUNC_ALLOC: begin
						// fresh slot at version zero, or flag a full table
						if (fc_q == '0 && fire) begin
							done = 1'b1;
							if (used_q != CNTW'(SLOTS)) begin
								meta_we     = 1'b1;
								meta_waddr  = used_q[IW-1:0];
								meta_wdata  = {1'b1, kind_q};
								ver_we      = 1'b1;
								ver_waddr   = used_q[IW-1:0];
								used_inc    = 1'b1;
								res_index   = IDX_W'(used_q[IW-1:0]);
							end else begin
								res_status = STAT_FULL;
							end
						end
					end
					FUNC_RELEASE: begin
						// drop the live mark, bump the version, push the slot
						if (fire) begin
							done = 1'b1;
							if (idx_oor) begin
								res_status = STAT_RANGE;
							end else if (!live) begin
								res_status = STAT_NOT_LIVE;
							end else begin
								meta_we   = 1'b1;
								ver_we    = 1'b1;
								ver_wdata = ver_inc;
								if (fc_q != CNTW'(SLOTS)) begin
									stk_we = 1'b1;
									fc_inc = 1'b1;
								end
							end
						end
					end
					FUNC_CHECK: begin
						if (fire) begin
							done = 1'b1;
							if (idx_oor) begin
								res_status = STAT_RANGE;
							end else if (!live) begin
								res_status = STAT_NOT_LIVE;
							end else begin
								res_ok = (VER_W'(ver_rdata) == hver_q);
								res_km = res_ok && (meta_rdata[KIND_W-1:0] == kind_q);
							end
						end
					end
					default: begin
					end
				endcase
			end
			ST_BUMP: begin
				// reuse a popped slot with its version bumped
				if (fire) begin
					done        = 1'b1;
					meta_we     = 1'b1;
					meta_waddr  = s_q;
					meta_wdata  = {1'b1, kind_q};
					ver_we      = 1'b1;
					ver_waddr   = s_q;
					ver_wdata   = ver_inc;
					fc_dec_en   = 1'b1;
					res_index   = IDX_W'(s_q);
					res_version = VER_W'(ver_inc);
				end
			end
			ST_CLR: begin
				// walk used slots: free each one and rebuild the stack in order
				if (clr_q != used_q) begin
					meta_we    = 1'b1;
					meta_waddr = clr_q[IW-1:0];
					stk_we     = 1'b1;
					stk_waddr  = clr_q[IW-1:0];
					stk_wdata  = clr_q[IW-1:0];
					clr_inc    = 1'b1;
				end else if (fire) begin
					done    = 1'b1;
					fc_load = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			fc_q        <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (used_inc) used_q <= used_q + CNTW'(1);
			if (fc_inc) fc_q <= fc_q + CNTW'(1);
			else if (fc_dec_en) fc_q <= fc_dec;
			else if (fc_load) fc_q <= used_q;
			if (accept) clr_q <= '0;
			else if (clr_inc) clr_q <= clr_q + CNTW'(1);
			if (done) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// capture the request beat and the popped slot
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= func_t'(func);
			idx_q  <= slot_index;
			hver_q <= handle_version;
			kind_q <= asset_kind;
		end
		if (state_q == ST_EXEC) begin
			s_q <= stk_rdata;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (done) begin
			out_index_q    <= res_index;
			out_version_q  <= res_version;
			handle_ok_q    <= res_ok;
			kind_matches_q <= res_km;
			status_q       <= res_status;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign out_index    = out_index_q;
	assign out_version  = out_version_q;
	assign handle_ok    = handle_ok_q;
	assign kind_matches = kind_matches_q;
	assign status       = status_q;

`ifndef SYNTHESIS
	a_free_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= used_q)
		else $error("free count exceeds used slots");

	a_used_le_slots: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNTW'(SLOTS))
		else $error("used slots exceed table size");

	a_clr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> (clr_q <= used_q))
		else $error("clear walk ran past used slots");

	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q != ST_IDLE))
		else $error("result raised without an operation in flight");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> req_stall)
		else $error("request taken while an operation is in flight");
`endif

endmodule

// ===== sv/ghal_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on ghal_pkg for default sizes.
module ghal_ram
	import ghal_pkg::*;
#(
	parameter int DEPTH = SLOTS_DEF,
	parameter int WIDTH = VERSION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
